// ----- src/swa_pkg.sv -----
// Shared types and constants for the stopwatch with window average.
// Holds payload structs, operation codes, sequencer states and divider status.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swa_pkg;

	// Window ring geometry
	localparam int WINDOW_MAX = 16;
	localparam int RING_AW    = $clog2(WINDOW_MAX);

	// Field and state widths
	localparam int OP_W   = 3;
	localparam int TICK_W = 48;
	localparam int SUM_W  = 64;
	localparam int CNT_W  = 32;
	localparam int FILL_W = 5;
	localparam int WSUM_W = 53;

	// Serial divider geometry
	localparam int DVD_W     = 64;
	localparam int DVS_W     = 32;
	localparam int DIV_CNT_W = $clog2(DVD_W);

	// Register port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_IDX_WINDOW_LENGTH = 1'b0;

	typedef enum logic [OP_W-1:0] {
		OP_START    = 3'd0,
		OP_PAUSE    = 3'd1,
		OP_RESUME   = 3'd2,
		OP_STOP     = 3'd3,
		OP_ADD_TIME = 3'd4,
		OP_ADD_MEAS = 3'd5
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [TICK_W-1:0] now;
		logic [TICK_W-1:0] duration;
	} swa_in_t;

	typedef struct packed {
		logic [TICK_W-1:0] elapsed_ticks;
		logic [TICK_W-1:0] window_average;
		logic [TICK_W-1:0] overall_average;
		logic [CNT_W-1:0]  measurement_count;
		logic [FILL_W-1:0] window_fill;
	} swa_out_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_REC,
		S_OLD,
		S_PUSH,
		S_DIVW,
		S_WAITW,
		S_DIVA,
		S_WAITA,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

// ----- src/swa_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// 64-bit dividend, 32-bit divisor; depends on swa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swa_div import swa_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output div_stat_t             stat,
	output logic      [DVD_W-1:0] quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;

	logic [DVS_W:0]   rem_sh;
	logic [DVS_W+1:0] diff;
	logic             fits;

	// one trial subtract per cycle
	always_comb begin
		rem_sh = {rem_q, dvd_q[DVD_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
		fits   = ~diff[DVS_W+1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {DIV_CNT_W{1'b1}}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits shift in where dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
			rem_q <= fits ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;

endmodule

`default_nettype wire

// ----- src/stopwatch_with_window_average.sv -----
// Stopwatch with window average: one result beat per input beat, one item at a time.
// Each of the two averages takes its turn on the shared serial divider (64 quotient
// bits plus handoff) and is skipped when its divisor is zero. A full result register
// holds the sequencer in its done state until the pending result beat is taken.
// Reset clears timing, totals, window state and window_length; ring is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module stopwatch_with_window_average import swa_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire swa_in_t           in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output swa_out_t               out_data,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	state_t state_q, state_d;

	// architectural state
	logic [FILL_W-1:0]  wl_q;
	logic [TICK_W-1:0]  begin_q;
	logic [TICK_W-1:0]  elapsed_q;
	logic [SUM_W-1:0]   total_q;
	logic [CNT_W-1:0]   count_q;
	logic [RING_AW-1:0] head_q;
	logic [FILL_W-1:0]  fill_q;
	logic [WSUM_W-1:0]  wsum_q;

	// working registers
	swa_in_t           cur_q;
	logic [TICK_W-1:0] meas_q;
	logic [TICK_W-1:0] win_avg_q;
	logic [TICK_W-1:0] all_avg_q;
	swa_out_t          out_q;
	logic              out_valid_q;

	// ring memory
	logic [TICK_W-1:0] ring_mem [WINDOW_MAX];
	logic [TICK_W-1:0] rd_q;

	// sequencer outputs
	logic             ring_rd;
	logic             ring_we;
	logic             div_start;
	logic             out_load;
	logic [DVD_W-1:0] div_dividend;
	logic [DVS_W-1:0] div_divisor;
	div_stat_t        div_stat;
	logic [DVD_W-1:0] div_quot;

	logic              cfg_wr;
	logic [FILL_W-1:0] win_len;
	logic              rec_op;
	logic [TICK_W-1:0] el_add;
	logic [TICK_W:0]   el_sum;
	logic [TICK_W-1:0] el_sat;
	logic [SUM_W:0]    tot_sum;
	logic [SUM_W-1:0]  tot_sat;
	logic [RING_AW-1:0] oldest;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready &
		(paddr[APB_AW-1] == REG_IDX_WINDOW_LENGTH);
	assign prdata = (paddr[APB_AW-1] == REG_IDX_WINDOW_LENGTH) ?
		{{(APB_DW-FILL_W){1'b0}}, wl_q} : '0;

	// effective window length and arithmetic helpers
	always_comb begin
		win_len = (wl_q > FILL_W'(WINDOW_MAX)) ? FILL_W'(WINDOW_MAX) : wl_q;
		rec_op  = (cur_q.operation == OP_STOP) || (cur_q.operation == OP_ADD_MEAS);
		el_add  = (cur_q.operation == OP_ADD_TIME) ? cur_q.duration : (cur_q.now - begin_q);
		el_sum  = {1'b0, elapsed_q} + {1'b0, el_add};
		el_sat  = el_sum[TICK_W] ? {TICK_W{1'b1}} : el_sum[TICK_W-1:0];
		tot_sum = {1'b0, total_q} + {{(SUM_W-TICK_W+1){1'b0}}, meas_q};
		tot_sat = tot_sum[SUM_W] ? {SUM_W{1'b1}} : tot_sum[SUM_W-1:0];
		oldest  = head_q - win_len[RING_AW-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_d = S_EXEC;
			S_EXEC:  state_d = rec_op ? S_REC : S_DIVW;
			S_REC: begin
				if (win_len == '0)
					state_d = S_DIVW;
				else if (fill_q >= win_len)
					state_d = S_OLD;
				else
					state_d = S_PUSH;
			end
			S_OLD:   state_d = S_PUSH;
			S_PUSH:  state_d = S_DIVW;
			S_DIVW:  state_d = (fill_q != '0) ? S_WAITW : S_DIVA;
			S_WAITW: if (div_stat.done) state_d = S_DIVA;
			S_DIVA:  state_d = (count_q != '0) ? S_WAITA : S_DONE;
			S_WAITA: if (div_stat.done) state_d = S_DONE;
			S_DONE:  if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready     = (state_q == S_IDLE);
		ring_rd      = (state_q == S_REC);
		ring_we      = (state_q == S_PUSH);
		out_load     = (state_q == S_DONE) && (!out_valid_q || out_ready);
		div_start    = ((state_q == S_DIVW) && (fill_q != '0)) ||
			((state_q == S_DIVA) && (count_q != '0));
		div_dividend = (state_q == S_DIVW) ? {{(DVD_W-WSUM_W){1'b0}}, wsum_q} : total_q;
		div_divisor  = (state_q == S_DIVW) ? {{(DVS_W-FILL_W){1'b0}}, fill_q} : count_q;
	end

	swa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	// ring: one write port at head, one registered read port at oldest
	always_ff @(posedge clk) begin
		if (ring_we)
			ring_mem[head_q] <= meas_q;
		if (ring_rd)
			rd_q <= ring_mem[oldest];
	end

	// state, counters and stopwatch registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			wl_q      <= '0;
			begin_q   <= '0;
			elapsed_q <= '0;
			total_q   <= '0;
			count_q   <= '0;
			head_q    <= '0;
			fill_q    <= '0;
			wsum_q    <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_EXEC: begin
					case (cur_q.operation)
						OP_START: begin
							begin_q   <= cur_q.now;
							elapsed_q <= '0;
						end
						OP_PAUSE, OP_STOP, OP_ADD_TIME: elapsed_q <= el_sat;
						OP_RESUME: begin_q <= cur_q.now;
						default: ;
					endcase
				end
				S_REC: begin
					total_q <= tot_sat;
					if (count_q != {CNT_W{1'b1}})
						count_q <= count_q + 1'b1;
					if ((win_len != '0) && (fill_q < win_len))
						fill_q <= fill_q + 1'b1;
				end
				S_OLD: begin
					wsum_q <= wsum_q - {{(WSUM_W-TICK_W){1'b0}}, rd_q};
					fill_q <= win_len;
				end
				S_PUSH: begin
					wsum_q <= wsum_q + {{(WSUM_W-TICK_W){1'b0}}, meas_q};
					head_q <= head_q + 1'b1;
				end
				default: ;
			endcase
			// window_length write empties the window
			if (cfg_wr) begin
				wl_q   <= pwdata[FILL_W-1:0];
				head_q <= '0;
				fill_q <= '0;
				wsum_q <= '0;
			end
		end
	end

	// item payload, measurement and averages
	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			cur_q <= in_data;
		if (state_q == S_EXEC)
			meas_q <= (cur_q.operation == OP_STOP) ? el_sat : cur_q.duration;
		if ((state_q == S_DIVW) && (fill_q == '0))
			win_avg_q <= '0;
		else if ((state_q == S_WAITW) && div_stat.done)
			win_avg_q <= div_quot[TICK_W-1:0];
		if ((state_q == S_DIVA) && (count_q == '0))
			all_avg_q <= '0;
		else if ((state_q == S_WAITA) && div_stat.done)
			all_avg_q <= div_quot[TICK_W-1:0];
		if (out_load)
			out_q <= '{elapsed_ticks: elapsed_q, window_average: win_avg_q,
				overall_average: all_avg_q, measurement_count: count_q,
				window_fill: fill_q};
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_fill_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= win_len)
		else $error("window fill exceeds window length");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !div_stat.busy)
		else $error("divider busy while sequencer idle");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> ((state_q == S_WAITW) || (state_q == S_WAITA)))
		else $error("divider finished outside a wait state");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result beat raised outside done state");
`endif

endmodule

`default_nettype wire

// ----- sim/stopwatch_with_window_average_tb.sv -----
// Self-checking bench for the stopwatch with window average: directed and random beats,
// with a cycle-accurate-free scoreboard predictor and random stalls on both channels.
// Depends on swa_pkg and the stopwatch_with_window_average top level.
`timescale 1ns / 1ps

module stopwatch_with_window_average_tb;
	import swa_pkg::*;

	localparam int CLK_HALF         = 5;
	localparam int RESET_CYCLES     = 9;
	localparam int CYCLE_LIMIT      = 1500000;
	localparam int DRAIN_CYCLES     = 150;
	localparam int RANDOM_ITEMS     = 1650;
	localparam int SHOWN_MISMATCHES = 10;
	localparam int EXP_DEPTH        = 16;

	// operation codes the block must ignore
	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	swa_in_t           in_data;
	logic              out_valid;
	logic              out_ready;
	swa_out_t          out_data;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	// predictor state
	logic [FILL_W-1:0]  win_len_reg;
	logic [TICK_W-1:0]  sw_begin;
	logic [TICK_W-1:0]  sw_elapsed;
	logic [SUM_W-1:0]   meas_total;
	logic [CNT_W-1:0]   meas_count;
	logic [TICK_W-1:0]  win_vals [WINDOW_MAX];
	logic [RING_AW-1:0] win_head;
	logic [FILL_W-1:0]  win_fill;
	logic [63:0]        win_sum;

	// expected results, in order: written at the input beat, read at the result beat
	swa_out_t exp_fifo [EXP_DEPTH];
	int       exp_wr;
	int       exp_rd;

	int          mismatches;
	int          cycles;
	int          sent;
	logic        no_idle;
	logic [TICK_W-1:0] stamp;

	stopwatch_with_window_average i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #CLK_HALF clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic logic [TICK_W-1:0] sat_add_ticks(input logic [TICK_W-1:0] a,
		input logic [TICK_W-1:0] b);
		logic [TICK_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TICK_W] ? TICK_MAX : s[TICK_W-1:0];
	endfunction

	task automatic clear_window_model();
		win_head = '0;
		win_fill = '0;
		win_sum  = '0;
	endtask

	task automatic reset_model();
		win_len_reg = '0;
		sw_begin    = '0;
		sw_elapsed  = '0;
		meas_total  = '0;
		meas_count  = '0;
		for (int i = 0; i < WINDOW_MAX; i++) win_vals[i] = '0;
		clear_window_model();
	endtask

	// total and count saturate; window drops its oldest value once full
	task automatic record_measurement(input logic [TICK_W-1:0] v);
		logic [SUM_W:0]     total_next;
		logic [FILL_W-1:0]  len;
		logic [RING_AW-1:0] oldest;
		len = (win_len_reg > WINDOW_MAX) ? FILL_W'(WINDOW_MAX) : win_len_reg;
		total_next = {1'b0, meas_total} + {{(SUM_W-TICK_W+1){1'b0}}, v};
		meas_total = total_next[SUM_W] ? '1 : total_next[SUM_W-1:0];
		if (meas_count != '1) meas_count++;
		if (len != 0) begin
			if (win_fill >= len) begin
				oldest = win_head - len[RING_AW-1:0];
				win_sum = win_sum - 64'(win_vals[oldest]);
				win_fill = len;
			end else begin
				win_fill++;
			end
			win_vals[win_head] = v;
			win_sum = win_sum + 64'(v);
			win_head++;
		end
	endtask

	task automatic apply_item(input swa_in_t item, output swa_out_t res);
		case (item.operation)
			OP_START: begin
				sw_begin   = item.now;
				sw_elapsed = '0;
			end
			OP_PAUSE: sw_elapsed = sat_add_ticks(sw_elapsed, item.now - sw_begin);
			OP_RESUME: sw_begin = item.now;
			OP_STOP: begin
				sw_elapsed = sat_add_ticks(sw_elapsed, item.now - sw_begin);
				record_measurement(sw_elapsed);
			end
			OP_ADD_TIME: sw_elapsed = sat_add_ticks(sw_elapsed, item.duration);
			OP_ADD_MEAS: record_measurement(item.duration);
			default: ;
		endcase
		res.elapsed_ticks     = sw_elapsed;
		res.window_average    = (win_fill != 0) ? TICK_W'(win_sum / win_fill) : '0;
		res.overall_average   = (meas_count != 0) ? TICK_W'(meas_total / meas_count) : '0;
		res.measurement_count = meas_count;
		res.window_fill       = win_fill;
	endtask

	// ---------------------------------------------------------------- random helpers

	function automatic logic [TICK_W-1:0] rand48();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[TICK_W-1:0];
	endfunction

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 7);
	endfunction

	// running timestamp: mostly small steps, sometimes a jump or a spot near the wrap
	function automatic logic [TICK_W-1:0] next_stamp();
		case ($urandom_range(0, 15))
			0: stamp = rand48();
			1: stamp = TICK_MAX - TICK_W'($urandom_range(0, 3000));
			default: stamp = stamp + TICK_W'($urandom_range(0, 5000));
		endcase
		return stamp;
	endfunction

	function automatic logic [TICK_W-1:0] rand_duration();
		return ($urandom_range(0, 7) == 0) ? rand48() : TICK_W'($urandom_range(0, 100000));
	endfunction

	function automatic logic [APB_DW-1:0] pick_window_length();
		logic [APB_DW-1:0] v;
		v = $urandom_range(0, 1) ? $urandom : '0;
		case ($urandom_range(0, 9))
			0: v[FILL_W-1:0] = 5'd0;
			1: v[FILL_W-1:0] = 5'd1;
			2: v[FILL_W-1:0] = 5'd16;
			3: v[FILL_W-1:0] = FILL_W'($urandom_range(17, 31));
			default: v[FILL_W-1:0] = FILL_W'($urandom_range(2, 15));
		endcase
		return v;
	endfunction

	// ---------------------------------------------------------------- channel drivers

	// one input beat; valid stays high across back-to-back beats
	task automatic send_item(input swa_in_t item);
		int gap;
		swa_out_t res;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		apply_item(item, res);
		exp_fifo[exp_wr % EXP_DEPTH] = res;
		exp_wr++;
		sent++;
	endtask

	task automatic send_op(input logic [OP_W-1:0] op, input logic [TICK_W-1:0] now_t,
		input logic [TICK_W-1:0] dur);
		swa_in_t item;
		item.operation = op;
		item.now       = now_t;
		item.duration  = dur;
		send_item(item);
	endtask

	task automatic idle_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (exp_wr != exp_rd) @(posedge clk);
	endtask

	// register write only once the block has returned every result
	task automatic set_window_length(input logic [APB_DW-1:0] value);
		idle_input();
		wait_drained();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({REG_IDX_WINDOW_LENGTH, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		win_len_reg = value[FILL_W-1:0];
		clear_window_model();
	endtask

	// result side: random stall before each beat
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// ---------------------------------------------------------------- scoreboard

	always @(posedge clk) begin : check_beat
		swa_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (exp_wr == exp_rd) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("result beat with nothing expected: elapsed %h count %h",
						out_data.elapsed_ticks, out_data.measurement_count);
			end else begin
				want = exp_fifo[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (out_data.elapsed_ticks !== want.elapsed_ticks ||
					out_data.window_average !== want.window_average ||
					out_data.overall_average !== want.overall_average ||
					out_data.measurement_count !== want.measurement_count ||
					out_data.window_fill !== want.window_fill) begin
					mismatches++;
					if (mismatches <= SHOWN_MISMATCHES) begin
						$display("mismatch (exp/got) elapsed %h/%h wavg %h/%h",
							want.elapsed_ticks, out_data.elapsed_ticks,
							want.window_average, out_data.window_average);
						$display("  oavg %h/%h count %h/%h fill %0d/%0d",
							want.overall_average, out_data.overall_average,
							want.measurement_count, out_data.measurement_count,
							want.window_fill, out_data.window_fill);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// right after reset: nothing recorded, both averages empty
	task automatic test_reset_state();
		send_op(OP_SPARE_A, rand48(), rand48());
	endtask

	task automatic test_each_operation();
		set_window_length(4);
		send_op(OP_START, 48'd100, '0);
		send_op(OP_ADD_TIME, 48'd120, 48'd50);
		send_op(OP_PAUSE, 48'd300, '0);
		send_op(OP_RESUME, 48'd1000, '0);
		send_op(OP_STOP, 48'd1100, '0);
		send_op(OP_ADD_MEAS, 48'd1200, '0);
		send_op(OP_ADD_MEAS, 48'd1300, TICK_MAX);
		send_op(OP_SPARE_B, rand48(), rand48());
	endtask

	task automatic test_elapsed_saturation();
		send_op(OP_START, '0, '0);
		send_op(OP_ADD_TIME, 48'd1, TICK_MAX);
		send_op(OP_ADD_TIME, 48'd2, 48'd1);
		send_op(OP_PAUSE, 48'd5, '0);
		send_op(OP_STOP, TICK_MAX, '0);
	endtask

	// timestamp wraps between start and stop
	task automatic test_stamp_wrap();
		send_op(OP_START, TICK_MAX - 48'd9, '0);
		send_op(OP_STOP, 48'd5, '0);
	endtask

	// window of one, oversized window, disabled window, largest code
	task automatic test_window_settings();
		set_window_length(1);
		send_op(OP_ADD_MEAS, '0, 48'd10);
		send_op(OP_ADD_MEAS, '0, 48'd20);
		send_op(OP_ADD_MEAS, '0, 48'd30);
		set_window_length(32'hFFFF_FFF1);
		send_op(OP_ADD_MEAS, '0, 48'd7);
		send_op(OP_ADD_MEAS, '0, 48'd8);
		set_window_length(0);
		send_op(OP_ADD_MEAS, '0, 48'd99);
		set_window_length(31);
		send_op(OP_ADD_MEAS, rand48(), rand48());
	endtask

	task automatic run_session();
		send_op(OP_START, next_stamp(), rand_duration());
		repeat ($urandom_range(0, 3)) begin
			if ($urandom_range(0, 2) == 0) send_op(OP_ADD_TIME, next_stamp(), rand_duration());
			send_op(OP_PAUSE, next_stamp(), rand_duration());
			send_op(OP_RESUME, next_stamp(), rand_duration());
		end
		send_op(OP_STOP, next_stamp(), rand_duration());
	endtask

	// phases of well-formed sessions, measurement bursts and raw noise
	task automatic test_random_traffic();
		int first;
		int phase;
		int phase_end;
		int pick;
		first = sent;
		phase = 0;
		while (sent < first + RANDOM_ITEMS) begin
			set_window_length(pick_window_length());
			no_idle = (phase % 4 == 3);
			phase_end = sent + $urandom_range(80, 220);
			while (sent < phase_end) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					run_session();
				else if (pick < 8)
					repeat ($urandom_range(1, 6))
						send_op(OP_ADD_MEAS, next_stamp(), rand_duration());
				else
					send_op(OP_W'($urandom_range(0, 7)), rand48(), rand48());
			end
			phase++;
		end
		no_idle = 1'b0;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		no_idle    = 1'b0;
		stamp      = '0;
		sent       = 0;
		exp_wr     = 0;
		exp_rd     = 0;
		mismatches = 0;
		cycles     = 0;
		reset_model();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_each_operation();
		test_elapsed_saturation();
		test_stamp_wrap();
		test_window_settings();
		test_random_traffic();

		idle_input();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (exp_wr != exp_rd) mismatches++;
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
